/* src/b64_pkg.sv */
`default_nettype none

package b64_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef enum logic [1:0] {
      KIND_ENCODE = 2'd0,
      KIND_DECODE = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_ALPHABET = 2'd1,
      ERR_LENGTH   = 2'd2
   } err_type;

   // One finished group: encode count = data characters, decode count = bytes
   typedef struct packed {
      kind_type    kind;
      logic [23:0] acc;
      logic [2:0]  count;
      logic        last;
      err_type     err;
   } desc_type;

   // Returns {in_alphabet, sextet}; '=' and bad characters give sextet zero
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

   function automatic logic [7:0] char_of(input logic [5:0] s);
      logic [7:0] c;
      if (s < 6'd26) begin
         c = 8'h41 + {2'b00, s};
      end else if (s < 6'd52) begin
         c = 8'h61 + {2'b00, s} - 8'd26;
      end else if (s < 6'd62) begin
         c = 8'h30 + {2'b00, s} - 8'd52;
      end else if (s == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/base64_stream_codec_unit.sv */
`default_nettype none

// Streaming base64 codec, standard alphabet with '=' padding. With direction 0
// it takes bytes and returns four characters for every three bytes (a short
// final group is zero-filled and padded); with direction 1 it takes characters
// and returns three bytes for every four, fewer in a padded final group, or a
// single error result for a bad character or a short stream. A front stage
// takes one item per cycle while the queue has room and collects groups;
// each finished group passes through a small queue (QUEUE_DEPTH entries) to
// a back stage that sends one result per cycle, while the output is ready,
// through a registered output. The output port sets the sustained rate when
// encoding, as three bytes give four results; decoding runs at one character
// per cycle when nothing stalls. A group's first result goes through a queue
// entry and the output register. A direction write clears the open group.

module base64_stream_codec_unit
   import b64_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,     // [7:0] data_in
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,     // [7:0] data_out
   output logic            rsp_tlast,
   output logic [1:0]      rsp_tuser,     // [1:0] error_code
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_wdata
);

   logic     push_valid, push_ready, pop_valid, pop_ready;
   desc_type push_desc, pop_desc;

   assign csr_ready  = 1'b1;
   assign req_tready = push_ready;

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_tvalid),
      .req_data   (req_tdata),
      .req_last   (req_tlast),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_desc  (push_desc)
   );

   b64_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_desc   (pop_desc),
      .pop_ready  (pop_ready)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_desc  (pop_desc),
      .pop_ready (pop_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast),
      .rsp_err   (rsp_tuser)
   );

endmodule

`default_nettype wire

/* src/b64_front.sv */
`default_nettype none

module b64_front
   import b64_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     csr_valid,
   input  wire logic     csr_wdata,
   input  wire logic     req_valid,
   input  wire logic [7:0] req_data,
   input  wire logic     req_last,
   input  wire logic     push_ready,
   output logic          push_valid,
   output desc_type      push_desc
);

   logic        dir_ff, dir_in;
   logic [23:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic        third_ff, third_in;

   logic [6:0]  sx;
   logic [23:0] enc_bits, dec_bits, acc_new;
   logic [2:0]  pos_next;
   logic        is_pad;

   assign sx     = sextet_of(req_data);
   assign is_pad = (req_data == PAD_CHAR);

   always_comb begin
      unique case (pos_ff)
         2'd0: enc_bits = {req_data, 16'h0000};
         2'd1: enc_bits = {8'h00, req_data, 8'h00};
         2'd2: enc_bits = {16'h0000, req_data};
         2'd3: enc_bits = {16'h0000, req_data};
      endcase
      unique case (pos_ff)
         2'd0: dec_bits = {sx[5:0], 18'b0};
         2'd1: dec_bits = {6'b0, sx[5:0], 12'b0};
         2'd2: dec_bits = {12'b0, sx[5:0], 6'b0};
         2'd3: dec_bits = {18'b0, sx[5:0]};
      endcase
   end

   always_comb begin
      dir_in     = dir_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      third_in   = third_ff;
      push_valid = 1'b0;
      push_desc  = '{kind: KIND_ENCODE, acc: 24'h0, count: 3'd0, last: req_last,
                     err: ERR_NONE};
      acc_new    = acc_ff | (dir_ff ? dec_bits : enc_bits);
      pos_next   = {1'b0, pos_ff} + 3'd1;

      if (req_valid && push_ready) begin
         if (!dir_ff) begin
            if (pos_next == 3'd3 || req_last) begin
               push_valid      = 1'b1;
               push_desc.acc   = acc_new;
               push_desc.count = pos_next + 3'd1;
               acc_in          = '0;
               pos_in          = '0;
            end else begin
               acc_in = acc_new;
               pos_in = pos_next[1:0];
            end
         end else begin
            priority if (!sx[6] && !is_pad) begin
               push_valid     = 1'b1;
               push_desc.kind = KIND_ERROR;
               push_desc.err  = ERR_ALPHABET;
               acc_in         = '0;
               pos_in         = '0;
               third_in       = 1'b0;
            end else if (req_last && pos_ff != 2'd3) begin
               push_valid     = 1'b1;
               push_desc.kind = KIND_ERROR;
               push_desc.err  = ERR_LENGTH;
               acc_in         = '0;
               pos_in         = '0;
               third_in       = 1'b0;
            end else if (pos_ff != 2'd3) begin
               acc_in = acc_new;
               pos_in = pos_next[1:0];
               if (pos_ff == 2'd2) begin
                  third_in = is_pad;
               end
            end else begin
               push_valid      = 1'b1;
               push_desc.kind  = KIND_DECODE;
               push_desc.acc   = acc_new;
               push_desc.count = req_last ?
                  (3'd3 - {2'b00, is_pad} - {2'b00, third_ff}) : 3'd3;
               acc_in          = '0;
               pos_in          = '0;
               third_in        = 1'b0;
            end
         end
      end

      // A direction write drops any group in progress
      if (csr_valid) begin
         dir_in   = csr_wdata;
         acc_in   = '0;
         pos_in   = '0;
         third_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= 1'b0;
         acc_ff   <= '0;
         pos_ff   <= '0;
         third_ff <= 1'b0;
      end else begin
         dir_ff   <= dir_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         third_ff <= third_in;
      end
   end

endmodule

`default_nettype wire

/* src/b64_queue.sv */
`default_nettype none

module b64_queue
   import b64_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH   // 2 or more
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire desc_type push_desc,
   output logic          push_ready,
   output logic          pop_valid,
   output desc_type      pop_desc,
   input  wire logic     pop_ready
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   desc_type        entry_ff [DEPTH];
   logic [IW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* src/b64_back.sv */
`default_nettype none

module b64_back
   import b64_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       pop_valid,
   input  wire desc_type   pop_desc,
   output logic            pop_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data,
   output logic            rsp_last,
   output logic [1:0]      rsp_err
);

   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_err_ff, rsp_err_in;
   logic [1:0]  idx_ff;
   logic [2:0]  total;
   logic        final_one, advance;
   logic [5:0]  sext;
   logic [7:0]  byte_sel;

   always_comb begin
      unique case (pop_desc.kind)
         KIND_ENCODE: total = 3'd4;
         KIND_DECODE: total = pop_desc.count;
         default:     total = 3'd1;
      endcase
      unique case (idx_ff)
         2'd0: sext = pop_desc.acc[23:18];
         2'd1: sext = pop_desc.acc[17:12];
         2'd2: sext = pop_desc.acc[11:6];
         2'd3: sext = pop_desc.acc[5:0];
      endcase
      unique case (idx_ff)
         2'd0:    byte_sel = pop_desc.acc[23:16];
         2'd1:    byte_sel = pop_desc.acc[15:8];
         default: byte_sel = pop_desc.acc[7:0];
      endcase
   end

   assign final_one = (({1'b0, idx_ff} + 3'd1) == total);
   assign advance   = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = advance && final_one;

   always_comb begin
      unique case (pop_desc.kind)
         KIND_ENCODE: begin
            rsp_data_in = ({1'b0, idx_ff} < pop_desc.count) ? char_of(sext) : PAD_CHAR;
            rsp_last_in = pop_desc.last && (idx_ff == 2'd3);
            rsp_err_in  = ERR_NONE;
         end
         KIND_DECODE: begin
            rsp_data_in = byte_sel;
            rsp_last_in = pop_desc.last && final_one;
            rsp_err_in  = ERR_NONE;
         end
         default: begin
            rsp_data_in = 8'h00;
            rsp_last_in = pop_desc.last;
            rsp_err_in  = pop_desc.err;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
         idx_ff       <= final_one ? '0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_err   = rsp_err_ff;

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_desc.kind == KIND_ERROR |-> idx_ff == 2'd0)
      else $error("error group started past its first result");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> ({1'b0, idx_ff} < total))
      else $error("result index ran past the group size");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff != ERR_NONE |-> rsp_data_ff == 8'h00)
      else $error("error result carries data");

   a_pop_resets_idx: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |=> idx_ff == 2'd0)
      else $error("index not cleared after group");

endmodule

`default_nettype wire

/* dv/testbench.sv */
module testbench
   import b64_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } stream_item_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      err_type    err;
   } codec_result_type;

   string b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [7:0] data_in
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] data_out
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;         // [1:0] error_code
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_wdata = 1'b0;

   stream_item_type  stream_items[$];
   codec_result_type b64_expected[$];

   int  items_pushed = 0;
   int  items_accepted = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;
   bit  csr_taken = 1'b0;

   int  req_gap = 0;
   int  req_run = 0;
   bit  req_calm = 1'b0;
   int  rsp_stall = 0;
   int  rsp_run = 0;
   bit  rsp_calm = 1'b0;

   // codec state as the block should hold it
   logic        dir_q = 1'b0;
   logic [23:0] grp_acc = '0;
   logic [1:0]  grp_pos = '0;
   logic        third_pad = 1'b0;

   base64_stream_codec_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Alternate stretches of random waits with stretches of none
   function automatic int draw_wait(inout int run_left, inout bit calm);
      if (run_left == 0) begin
         run_left = $urandom_range(5, 40);
         calm = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic int sextet_lookup(input logic [7:0] c);
      for (int k = 0; k < 64; k++) begin
         if (b64_alphabet[k] == c) begin
            return k;
         end
      end
      return -1;
   endfunction

   task automatic clear_group();
      grp_acc = '0;
      grp_pos = '0;
      third_pad = 1'b0;
   endtask

   task automatic add_result(input logic [7:0] d, input logic l, input err_type e);
      codec_result_type r;
      r.data = d;
      r.last = l;
      r.err = e;
      b64_expected.push_back(r);
   endtask

   task automatic b64_predict(input logic [7:0] c, input logic last);
      int pos;
      int s;
      int n;
      int v;
      logic is_pad;
      logic [7:0] ch;
      pos = grp_pos;
      if (dir_q == 1'b0) begin
         grp_acc = grp_acc | (24'(c) << (16 - 8 * pos));
         pos++;
         if (pos < 3 && !last) begin
            grp_pos = 2'(pos);
         end else begin
            n = pos + 1;
            for (int k = 0; k < 4; k++) begin
               ch = (k < n) ? b64_alphabet[(grp_acc >> (18 - 6 * k)) & 24'h3F] : PAD_CHAR;
               add_result(ch, last && k == 3, ERR_NONE);
            end
            clear_group();
         end
      end else begin
         s = sextet_lookup(c);
         is_pad = (c == PAD_CHAR);
         if (s < 0 && !is_pad) begin
            add_result(8'h00, last, ERR_ALPHABET);
            clear_group();
         end else if (last && pos != 3) begin
            add_result(8'h00, 1'b1, ERR_LENGTH);
            clear_group();
         end else begin
            v = (s < 0) ? 0 : s;
            grp_acc = grp_acc | (24'(v) << (18 - 6 * pos));
            if (pos == 2) begin
               third_pad = is_pad;
            end
            if (pos < 3) begin
               grp_pos = 2'(pos + 1);
            end else begin
               n = 3;
               if (last) begin
                  n = 3 - int'(is_pad) - int'(third_pad);
               end
               for (int k = 0; k < n; k++) begin
                  add_result(8'((grp_acc >> (16 - 8 * k)) & 24'hFF), last && k + 1 == n,
                             ERR_NONE);
               end
               clear_group();
            end
         end
      end
   endtask

   // Driver: one item per transaction, random gap after each
   always @(negedge clock) begin
      stream_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold until accepted
      end else begin
         if (req_tvalid) begin
            req_gap = draw_wait(req_run, req_calm);
         end
         if (req_gap > 0 || stream_items.size() == 0) begin
            if (req_gap > 0) begin
               req_gap--;
            end
            req_tvalid <= 1'b0;
         end else begin
            item = stream_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.data;
            req_tlast <= item.last;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_stall = draw_wait(rsp_run, rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      codec_result_type want;
      cycle_count++;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      csr_taken = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_taken = 1'b1;
            dir_q = csr_wdata;
            clear_group();
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            if (b64_expected.size() == 0) begin
               $display("%0t: unexpected result data_out %h last_out %b error_code %0d",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               mismatch_count++;
            end else begin
               want = b64_expected.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: data_out expected %h actual %h", $time, want.data, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_out expected %b actual %b", $time, want.last, rsp_tlast);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.err) begin
                  $display("%0t: error_code expected %0d actual %0d", $time, want.err,
                           rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            items_accepted++;
            b64_predict(req_tdata, req_tlast);
         end
      end
   end

   task automatic push_item(input logic [7:0] d, input logic l);
      stream_item_type item;
      item.data = d;
      item.last = l;
      stream_items.push_back(item);
      items_pushed++;
   endtask

   task automatic push_text(input string txt, input logic l);
      for (int k = 0; k < txt.len(); k++) begin
         push_item(txt[k], l && k == txt.len() - 1);
      end
   endtask

   // Wait for every item taken and every result seen, then let the pipe empty
   task automatic settle_codec();
      do @(negedge clock);
      while (items_accepted != items_pushed || b64_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic dir);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = dir;
      do @(negedge clock);
      while (!csr_taken);
      csr_valid = 1'b0;
   endtask

   task automatic gen_byte_stream(inout int budget);
      int len;
      logic [7:0] b;
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         // now and then leave the stream open across the next one
         push_item(b, k == len - 1 && $urandom_range(0, 9) != 0);
         budget--;
      end
   endtask

   task automatic gen_text_stream(inout int budget);
      logic [7:0] txt[$];
      int ngroups;
      int cut;
      int sz;
      logic tail;
      ngroups = $urandom_range(1, 3);
      for (int k = 0; k < 4 * ngroups; k++) begin
         txt.push_back(b64_alphabet[$urandom_range(0, 63)]);
      end
      sz = txt.size();
      case ($urandom_range(0, 4))
         1: txt[sz - 1] = PAD_CHAR;
         2: begin
            txt[sz - 2] = PAD_CHAR;
            txt[sz - 1] = PAD_CHAR;
         end
         3: txt[sz - 2] = PAD_CHAR;
         default: ;
      endcase
      if ($urandom_range(0, 5) == 0) begin
         txt[$urandom_range(0, sz - 1)] =
            ($urandom_range(0, 2) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, 3);
         repeat (cut) void'(txt.pop_back());
      end
      tail = ($urandom_range(0, 15) != 0);
      sz = txt.size();
      for (int k = 0; k < sz; k++) begin
         push_item(txt[k], tail && k == sz - 1);
         budget--;
      end
   endtask

   initial begin
      logic phase_dir[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      int budget;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // encode after reset: byte extremes, one and two byte final groups
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h80, 1'b0);
      push_item(8'h4D, 1'b1);
      push_item(8'h4D, 1'b0);
      push_item(8'h61, 1'b1);
      settle_codec();

      write_direction(1'b1);
      push_text("+/9=", 1'b0);   // pad outside the final group
      push_text("TQ==", 1'b1);
      push_text("=W=u", 1'b1);   // pad in first and third place only
      push_text("T*", 1'b0);     // bad character mid-group
      push_text("Tw", 1'b0);
      push_item(8'hFF, 1'b1);    // bad character that is also last
      push_text("az", 1'b1);     // short stream
      push_text("TW", 1'b0);     // group left open across the next write
      settle_codec();

      foreach (phase_dir[p]) begin
         write_direction(phase_dir[p]);
         budget = 50;
         while (budget > 0) begin
            if (phase_dir[p] == 1'b0) begin
               gen_byte_stream(budget);
            end else begin
               gen_text_stream(budget);
            end
         end
         settle_codec();
      end

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule
